@@ rtl/core/polynomial_bisection_root_assert.svh @@
// Assertion macros used by the polynomial bisection root controller.
`ifndef POLYNOMIAL_BISECTION_ROOT_ASSERT_SVH
`define POLYNOMIAL_BISECTION_ROOT_ASSERT_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define PBR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define PBR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/pbr_pkg.sv @@
// Package: types, constants and command/status structs of the bisection root block.
package pbr_pkg;

  localparam int MAX_DEGREE = 6;
  localparam int NUM_COEF   = MAX_DEGREE + 1;
  localparam int STEP_W     = $clog2(NUM_COEF);
  localparam int TOL_W      = 17;
  localparam int CFG_IDX_W  = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_0    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(NUM_COEF);

  // evaluation point select
  localparam logic [1:0] XSEL_LO  = 2'd0;
  localparam logic [1:0] XSEL_HI  = 2'd1;
  localparam logic [1:0] XSEL_MID = 2'd2;

  // result select
  localparam logic [2:0] RES_ACC = 3'd0;
  localparam logic [2:0] RES_LO  = 3'd1;
  localparam logic [2:0] RES_HI  = 3'd2;
  localparam logic [2:0] RES_X   = 3'd3;
  localparam logic [2:0] RES_MID = 3'd4;

  typedef struct packed {
    logic               func;
    logic signed [31:0] x_low;
    logic signed [31:0] x_high;
  } pbr_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               exact_zero;
  } pbr_out_t;

  typedef struct packed {
    logic              load_item;
    logic              x_load;
    logic [1:0]        x_sel;
    logic              acc_init;
    logic              mul;
    logic              add;
    logic [STEP_W-1:0] step;
    logic              upd_hi;
    logic              upd_lo;
    logic              set_plo;
    logic              res_load;
    logic [2:0]        res_sel;
    logic              res_exact;
    logic              out_load;
  } pbr_cmd_t;

  typedef struct packed {
    logic acc_zero;
    logic sign_diff;
    logic wide;
  } pbr_stat_t;

endpackage

@@ rtl/core/pbr_datapath.sv @@
// Datapath: coefficient registers, Horner multiply-add unit, interval and result registers.
module pbr_datapath import pbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  pbr_in_t              in_data,
  input  pbr_cmd_t             cmd,
  output pbr_stat_t            stat,
  output pbr_out_t             out_data
);

  logic signed [31:0] coef [NUM_COEF];
  logic [TOL_W-1:0]   tol;
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic signed [31:0] x;
  logic signed [31:0] acc;
  logic signed [63:0] prod;
  logic               plo_sign;
  logic signed [31:0] res_val;
  logic               res_exact;

  logic signed [48:0] sum;
  logic signed [31:0] acc_next;
  logic signed [32:0] lo_hi_sum;
  logic signed [31:0] mid;
  logic signed [32:0] width;
  logic [TOL_W-1:0]   tol_eff;
  logic signed [31:0] x_next;
  logic signed [31:0] res_next;

  // floor shift of the Q32.32 product back to Q16.16, then add and clamp
  assign sum = 49'(prod >>> 16) + 49'(coef[cmd.step]);

  always_comb begin
    if (sum > 49'sh0_7FFF_FFFF) begin
      acc_next = 32'sh7FFF_FFFF;
    end else if (sum < -49'sh0_8000_0000) begin
      acc_next = -32'sh8000_0000;
    end else begin
      acc_next = sum[31:0];
    end
  end

  assign lo_hi_sum = {lo[31], lo} + {hi[31], hi};
  assign mid       = lo_hi_sum[32:1];
  assign width     = {hi[31], hi} - {lo[31], lo};
  assign tol_eff   = (tol == '0) ? TOL_W'(1) : tol;

  assign stat.acc_zero  = (acc == '0);
  assign stat.sign_diff = plo_sign ^ acc[31];
  assign stat.wide      = width > $signed({16'b0, tol_eff});

  always_comb begin
    case (cmd.x_sel)
      XSEL_LO:  x_next = lo;
      XSEL_HI:  x_next = hi;
      XSEL_MID: x_next = mid;
      default:  x_next = lo;
    endcase
  end

  always_comb begin
    case (cmd.res_sel)
      RES_ACC: res_next = acc;
      RES_LO:  res_next = lo;
      RES_HI:  res_next = hi;
      RES_X:   res_next = x;
      RES_MID: res_next = mid;
      default: res_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef[i] <= '0;
      end
      tol <= TOL_W'(1);
    end else if (cfg_we) begin
      if (cfg_index < CFG_TOLERANCE) begin
        coef[cfg_index[STEP_W-1:0]] <= cfg_data;
      end else if (cfg_index == CFG_TOLERANCE) begin
        tol <= cfg_data[TOL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      lo <= in_data.x_low;
      hi <= in_data.x_high;
      x  <= in_data.x_low;
    end else begin
      if (cmd.x_load) x <= x_next;
      if (cmd.upd_hi) hi <= x;
      if (cmd.upd_lo) lo <= x;
    end
    if (cmd.acc_init) begin
      acc <= coef[MAX_DEGREE];
    end else if (cmd.add) begin
      acc <= acc_next;
    end
    if (cmd.mul) prod <= acc * x;
    if (cmd.set_plo) plo_sign <= acc[31];
    if (cmd.res_load) begin
      res_val   <= res_next;
      res_exact <= cmd.res_exact;
    end
    if (cmd.out_load) begin
      out_data.result_value <= res_val;
      out_data.exact_zero   <= res_exact;
    end
  end

endmodule

@@ rtl/core/pbr_ctrl.sv @@
// Controller: sequences Horner passes, end-point tests and bisection halvings.
`include "polynomial_bisection_root_assert.svh"
module pbr_ctrl import pbr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      func,
  output logic      out_valid,
  input  logic      out_ready,
  input  pbr_stat_t stat,
  output pbr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HMUL   = 3'd1;
  localparam logic [2:0] S_HADD   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_LOOP   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  localparam logic [1:0] PH_EVAL = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_MID  = 2'd3;

  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(MAX_DEGREE - 1);

  logic [2:0]        state, state_next;
  logic [1:0]        phase, phase_next;
  logic [STEP_W-1:0] step, step_next;

  always_comb begin
    cmd        = '0;
    cmd.step   = step;
    in_ready   = 1'b0;
    state_next = state;
    phase_next = phase;
    step_next  = step;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.acc_init  = 1'b1;
          step_next     = STEP_FIRST;
          phase_next    = func ? PH_LO : PH_EVAL;
          state_next    = S_HMUL;
        end
      end
      S_HMUL: begin
        cmd.mul    = 1'b1;
        state_next = S_HADD;
      end
      S_HADD: begin
        cmd.add = 1'b1;
        if (step == '0) begin
          state_next = S_CHECK;
        end else begin
          step_next  = step - STEP_W'(1);
          state_next = S_HMUL;
        end
      end
      S_CHECK: begin
        case (phase)
          PH_EVAL: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ACC;
            state_next   = S_FINISH;
          end
          PH_LO: begin
            if (stat.acc_zero) begin
              cmd.res_load  = 1'b1;
              cmd.res_sel   = RES_LO;
              cmd.res_exact = 1'b1;
              state_next    = S_FINISH;
            end else begin
              cmd.set_plo  = 1'b1;
              cmd.x_load   = 1'b1;
              cmd.x_sel    = XSEL_HI;
              cmd.acc_init = 1'b1;
              step_next    = STEP_FIRST;
              phase_next   = PH_HI;
              state_next   = S_HMUL;
            end
          end
          PH_HI: begin
            if (stat.acc_zero) begin
              cmd.res_load  = 1'b1;
              cmd.res_sel   = RES_HI;
              cmd.res_exact = 1'b1;
              state_next    = S_FINISH;
            end else begin
              state_next = S_LOOP;
            end
          end
          default: begin
            if (stat.acc_zero) begin
              cmd.res_load  = 1'b1;
              cmd.res_sel   = RES_X;
              cmd.res_exact = 1'b1;
              state_next    = S_FINISH;
            end else begin
              if (stat.sign_diff) begin
                cmd.upd_hi = 1'b1;
              end else begin
                cmd.upd_lo  = 1'b1;
                cmd.set_plo = 1'b1;
              end
              state_next = S_LOOP;
            end
          end
        endcase
      end
      S_LOOP: begin
        if (stat.wide) begin
          cmd.x_load   = 1'b1;
          cmd.x_sel    = XSEL_MID;
          cmd.acc_init = 1'b1;
          step_next    = STEP_FIRST;
          phase_next   = PH_MID;
          state_next   = S_HMUL;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_MID;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_EVAL;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      step  <= step_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PBR_ASSERT_NXT(a_accept_starts_horner, in_valid && in_ready, state == S_HMUL, "item did not start a Horner pass")
  `PBR_ASSERT_NXT(a_last_step_checks, state == S_HADD && step == '0, state == S_CHECK, "Horner pass overran its last step")
  `PBR_ASSERT_NXT(a_finish_holds, state == S_FINISH && out_valid && !out_ready, state == S_FINISH && out_valid, "finished item lost while output stalled")
  `PBR_ASSERT_IMP(a_eval_not_exact, state == S_CHECK && phase == PH_EVAL, !cmd.res_exact, "evaluation flagged exact zero")

endmodule

@@ rtl/core/polynomial_bisection_root.sv @@
// Evaluate: one Horner pass of 6 steps (each a 32x32 multiply, then shift/add/clamp), one check
// state and one output load. Root search: two end-point passes, then one Horner pass per halving,
// up to 32 halvings; one item in flight, next taken once idle.
// A finished result waits in the output register; a new item may be accepted meanwhile.
// Synchronous active-high reset: coefficients clear to 0, tolerance to 1, output empty.
module polynomial_bisection_root import pbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pbr_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pbr_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // command and status buses between controller and datapath
  pbr_cmd_t  cmd;
  pbr_stat_t stat;

  // register file never stalls a write; writes take effect at the handshake edge
  assign cfg_ready = 1'b1;

  pbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (in_data.func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Horner unit, interval bounds, coefficient/tolerance registers and output item
  pbr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

@@ dv/tb_polynomial_bisection_root.sv @@
// Self-checking testbench for the polynomial evaluate / bisection root block.
module tb_polynomial_bisection_root;
  timeunit 1ns;
  timeprecision 1ps;
  import pbr_pkg::*;

  // Q16.16 helpers and codes used by the stimulus
  localparam int ONE = 65536;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  localparam logic FUNC_EVAL = 1'b0;
  localparam logic FUNC_ROOT = 1'b1;

  // index past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = '1;

  localparam int GAP_MAX      = 17;
  localparam int HOLD_CYCLES  = 600;   // long receiver stall, fills the block
  localparam int DRAIN_CYCLES = 600;   // longer than the worst root search
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 50;
  localparam int HOLD_PHASE   = 4;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // one line of the directed table: a register write or an item
  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [31:0]          reg_value;
    pbr_in_t              item;
    logic                 pinned;    // expectation typed in below
    pbr_out_t             want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  pbr_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  pbr_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // shadow copy of the register file, updated at each write handshake
  logic signed [31:0] coefs [NUM_COEF];
  logic [TOL_W-1:0]   tol_reg;

  pbr_out_t  awaited_results [$];
  plan_row_t plan [$];

  // knobs set by the main sequence for the sender and the receiver
  bit tx_lazy;
  bit rx_lazy;
  bit rx_hold;

  int mismatches;
  int items_sent;
  int evals_sent;
  int searches_sent;
  int exact_seen;
  int reg_writes;

  always #10 clk = ~clk;

  polynomial_bisection_root dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Horner evaluation: full 64-bit product, floor shift by 16, add, clamp.
  // Clamped partial sums feed the next step.
  function automatic longint horner_q16(longint x);
    longint acc;
    longint term;
    int     k;
    acc = coefs[MAX_DEGREE];
    for (k = MAX_DEGREE - 1; k >= 0; k--) begin
      term = coefs[k] + ((acc * x) >>> 16);
      if (term > SAT_HI) acc = SAT_HI;
      else if (term < SAT_LO) acc = SAT_LO;
      else acc = term;
    end
    return acc;
  endfunction

  // Value of p(x_low), or the bisection root estimate with its exact flag.
  function automatic pbr_out_t solve_item(pbr_in_t it);
    pbr_out_t r;
    longint   lo;
    longint   hi;
    longint   tol;
    longint   mid;
    longint   p_lo;
    longint   p_mid;
    bit       found;
    lo = it.x_low;
    hi = it.x_high;
    r.exact_zero = 1'b0;
    if (it.func == FUNC_EVAL) begin
      r.result_value = 32'(horner_q16(lo));
      return r;
    end
    // zero tolerance behaves as one LSB
    tol  = (tol_reg == 0) ? 1 : longint'(tol_reg);
    p_lo = horner_q16(lo);
    if (p_lo == 0) begin
      r.result_value = 32'(lo);
      r.exact_zero   = 1'b1;
    end else if (horner_q16(hi) == 0) begin
      r.result_value = 32'(hi);
      r.exact_zero   = 1'b1;
    end else begin
      // reversed interval skips this loop and lands on the floor midpoint
      found = 1'b0;
      while (!found && (hi - lo > tol)) begin
        mid   = (lo + hi) >>> 1;
        p_mid = horner_q16(mid);
        if (p_mid == 0) begin
          found          = 1'b1;
          r.result_value = 32'(mid);
          r.exact_zero   = 1'b1;
        end else if ((p_lo < 0) != (p_mid < 0)) begin
          hi = mid;
        end else begin
          lo   = mid;
          p_lo = p_mid;
        end
      end
      if (!found) r.result_value = 32'((lo + hi) >>> 1);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    plan_row_t row;
    row.kind      = ROW_CFG;
    row.reg_index = idx;
    row.reg_value = value;
    row.item      = '0;
    row.pinned    = 1'b0;
    row.want      = '0;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_pinned(logic f, logic [31:0] lo, logic [31:0] hi,
                                     logic pin, logic [31:0] val, logic zero);
    plan_row_t row;
    row.kind              = ROW_ITEM;
    row.reg_index         = '0;
    row.reg_value         = '0;
    row.item.func         = f;
    row.item.x_low        = lo;
    row.item.x_high       = hi;
    row.pinned            = pin;
    row.want.result_value = val;
    row.want.exact_zero   = zero;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_item(logic f, logic [31:0] lo, logic [31:0] hi);
    add_pinned(f, lo, hi, 1'b0, '0, 1'b0);
  endfunction

  // uniform Q16.16 value in [-whole, +whole]
  function automatic logic [31:0] rand_q(int whole);
    return $urandom_range(0, 2 * whole * ONE) - whole * ONE;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------

  // Offer one item; valid stays up without a dip when no gap is drawn.
  task automatic offer(pbr_in_t it, pbr_out_t want);
    int gap;
    gap = tx_lazy ? $urandom_range(0, GAP_MAX) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    awaited_results.insert(awaited_results.size(), want);
    items_sent++;
    if (it.func == FUNC_EVAL) evals_sent++;
    else searches_sent++;
  endtask

  // Register write; the caller lowers cfg_valid after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx < CFG_TOLERANCE) coefs[STEP_W'(idx - CFG_COEF_0)] = value;
    else if (idx == CFG_TOLERANCE) tol_reg = value[TOL_W-1:0];
    reg_writes++;
  endtask

  // Stop offering and wait until every item has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, one long hold on request, in-order check
  // ---------------------------------------------------------------------------
  initial begin
    int       wait_n;
    pbr_out_t want;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_hold) begin
        rx_hold = 1'b0;
        wait_n  = HOLD_CYCLES;
      end else begin
        wait_n = rx_lazy ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (out_data.exact_zero === 1'b1) exact_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%t unexpected result: value %h exact %b", $realtime,
                   out_data.result_value, out_data.exact_zero);
      end else begin
        want = awaited_results.pop_front();
        if (out_data.result_value !== want.result_value ||
            out_data.exact_zero !== want.exact_zero) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%t mismatch: value exp %h got %h, exact exp %b got %b", $realtime,
                     want.result_value, out_data.result_value,
                     want.exact_zero, out_data.exact_zero);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int               ph;
    int               n;
    int               k;
    int               shape;
    int               deg;
    int               r1;
    int               r2;
    logic [31:0]      coef_w [NUM_COEF];
    logic [TOL_W-1:0] tol_w;
    logic [31:0]      a;
    logic [31:0]      b;
    pbr_in_t          it;
    bit               in_cfg;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (k = 0; k < NUM_COEF; k++) coefs[k] = '0;
    tol_reg   = 1;
    tx_lazy   = 1'b1;
    rx_lazy   = 1'b1;
    rx_hold   = 1'b0;
    in_cfg    = 1'b0;

    // --- directed table ---
    // out of reset p(x) = 0: every evaluation is 0, every search hits x_low
    add_pinned(FUNC_EVAL, Q_MAX, Q_MIN, 1'b1, '0, 1'b0);
    add_pinned(FUNC_EVAL, Q_MIN, Q_MAX, 1'b1, '0, 1'b0);
    add_pinned(FUNC_ROOT, 5 * ONE, -3 * ONE, 1'b1, 5 * ONE, 1'b1);

    // p(x) = x^2 - 4: exact zeros at either end, at a midpoint, reversed ends
    add_cfg(CFG_COEF_0, -4 * ONE);
    add_cfg(CFG_IDX_W'(CFG_COEF_0 + 2), ONE);
    add_item(FUNC_EVAL, 3 * ONE, '0);
    add_pinned(FUNC_ROOT, 2 * ONE, 5 * ONE, 1'b1, 2 * ONE, 1'b1);
    add_pinned(FUNC_ROOT, '0, 2 * ONE, 1'b1, 2 * ONE, 1'b1);
    add_item(FUNC_ROOT, '0, 4 * ONE);
    add_item(FUNC_ROOT, -3 * ONE, ONE);
    add_pinned(FUNC_ROOT, 3 * ONE, 2 * ONE, 1'b1, 2 * ONE, 1'b1);
    add_pinned(FUNC_ROOT, 3 * ONE, ONE, 1'b1, 2 * ONE, 1'b0);
    add_item(FUNC_ROOT, Q_MIN, Q_MAX);

    // zero tolerance must still terminate
    add_cfg(CFG_TOLERANCE, '0);
    add_item(FUNC_ROOT, '0, 3 * ONE);

    // p(x) = x^2 - 2: irrational roots, bisection runs to the tolerance
    add_cfg(CFG_COEF_0, -2 * ONE);
    add_item(FUNC_ROOT, '0, 2 * ONE);
    add_item(FUNC_ROOT, -2 * ONE, '0);
    add_cfg(CFG_TOLERANCE, ONE);
    add_item(FUNC_ROOT, '0, Q_MAX);
    add_item(FUNC_EVAL, 32'hFFFF_FFFF, '0);

    // all coefficients at the extremes: clamping at every step
    for (k = 0; k < NUM_COEF; k++) add_cfg(CFG_IDX_W'(CFG_COEF_0 + k), Q_MAX);
    add_cfg(CFG_TOLERANCE, 1);
    add_pinned(FUNC_EVAL, Q_MAX, '0, 1'b1, Q_MAX, 1'b0);
    add_item(FUNC_EVAL, Q_MIN, '0);
    add_item(FUNC_ROOT, Q_MIN, Q_MAX);
    for (k = 0; k < NUM_COEF; k++) add_cfg(CFG_IDX_W'(CFG_COEF_0 + k), Q_MIN);
    add_cfg(CFG_SPARE, 32'hA5A5_5A5A);
    add_pinned(FUNC_EVAL, Q_MAX, '0, 1'b1, Q_MIN, 1'b0);
    add_item(FUNC_EVAL, 32'hFFFF_FFFF, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the table. A run of register rows first waits for the block to
    // empty; the expectation comes from the table or from the predictor.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!in_cfg) begin
          drain();
          in_cfg = 1'b1;
        end
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        if (in_cfg) begin
          cfg_valid <= 1'b0;
          in_cfg = 1'b0;
        end
        offer(plan[i].item, plan[i].pinned ? plan[i].want : solve_item(plan[i].item));
      end
    end

    // --- random phases: new polynomial and tolerance each time ---
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      for (k = 0; k < NUM_COEF; k++) coef_w[k] = '0;
      case (ph % 4)
        0: begin
          // raw 32-bit coefficients, mostly saturating
          for (k = 0; k < NUM_COEF; k++) coef_w[k] = $urandom();
        end
        1: begin
          // small coefficients up to a random degree
          deg = $urandom_range(1, MAX_DEGREE);
          for (k = 0; k <= deg; k++) coef_w[k] = rand_q(4);
        end
        2: begin
          // (x - r1)(x - r2) with integer roots, so midpoints can hit zero
          r1 = int'($urandom_range(0, 10)) - 5;
          r2 = int'($urandom_range(0, 10)) - 5;
          coef_w[0] = r1 * r2 * ONE;
          coef_w[1] = -(r1 + r2) * ONE;
          coef_w[2] = ONE;
        end
        default: begin
          // linear with an arbitrary root
          coef_w[0] = rand_q(8);
          coef_w[1] = rand_q(4);
        end
      endcase
      case ($urandom_range(0, 5))
        0: tol_w = '0;
        1: tol_w = 1;
        2: tol_w = TOL_W'(ONE);
        3: tol_w = '1;
        default: tol_w = TOL_W'($urandom_range(1, 4096));
      endcase
      for (k = 0; k < NUM_COEF; k++) write_reg(CFG_IDX_W'(CFG_COEF_0 + k), coef_w[k]);
      write_reg(CFG_TOLERANCE, 32'(tol_w));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom());
      cfg_valid <= 1'b0;

      tx_lazy = ($urandom_range(0, 3) != 0);
      rx_lazy = ($urandom_range(0, 3) != 0);
      if (ph == HOLD_PHASE) begin
        // sender streams while the receiver sits out a long hold
        tx_lazy = 1'b0;
        rx_hold = 1'b1;
      end

      for (n = 0; n < PHASE_ITEMS; n++) begin
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
          a = $urandom();
          b = $urandom();
        end else if (shape == 1) begin
          // reversed ends
          a = rand_q(8);
          b = rand_q(8);
          if ($signed(a) < $signed(b)) begin
            a = a ^ b;
            b = a ^ b;
            a = a ^ b;
          end
        end else if (shape <= 4) begin
          // whole-number ends around the integer roots
          a = (int'($urandom_range(0, 16)) - 8) * ONE;
          b = a + $urandom_range(1, 12) * ONE;
        end else begin
          a = rand_q(8);
          b = a + $urandom_range(1, 8 * ONE);
        end
        it.func   = $urandom_range(0, 1) ? FUNC_ROOT : FUNC_EVAL;
        it.x_low  = a;
        it.x_high = b;
        offer(it, solve_item(it));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items: %0d evaluations, %0d root searches, %0d exact zeros",
             items_sent, evals_sent, searches_sent, exact_seen);
    $display("register writes: %0d over %0d random settings plus the directed table",
             reg_writes, PHASES);
    if (mismatches == 0) begin
      $display("tb_polynomial_bisection_root: done, clean");
    end else begin
      $display("tb_polynomial_bisection_root: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every item a full search
  // plus both sides' longest gaps, the long hold and every drain).
  initial begin
    #40ms;
    $display("tb_polynomial_bisection_root: done, errors");
    $finish;
  end

endmodule

@@ polynomial_bisection_root.f @@
+incdir+rtl/core
rtl/core/pbr_pkg.sv
rtl/core/pbr_datapath.sv
rtl/core/pbr_ctrl.sv
rtl/core/polynomial_bisection_root.sv
dv/tb_polynomial_bisection_root.sv
